// ----- src/nss_pkg.sv -----
// shared constants, types and command/status structs for the substring search block
package nss_pkg;

   localparam int PAT_DEPTH = 32;
   localparam int MAX_TEXT  = 65536;
   localparam int SYM_W     = 16;
   localparam int POS_W     = 16;
   localparam int LEN_W     = $clog2(PAT_DEPTH + 1);
   localparam int CNT_W     = $clog2(MAX_TEXT + 1);
   localparam int CMP_W     = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;

   // item kinds
   localparam logic MODE_PATTERN = 1'b0;
   localparam logic MODE_TEXT    = 1'b1;

   // controller states
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_CMP  = 1'b1;

   typedef logic [SYM_W-1:0] sym_type;
   typedef logic [POS_W-1:0] pos_type;

   typedef struct packed {
      logic item_load;
      logic out_load;
   } nss_cmd_type;

   typedef struct packed {
      logic match;
   } nss_sts_type;

endpackage

// ----- src/nss_if.sv -----
// valid/ready channel interfaces for search requests and match responses
interface nss_req_if
   import nss_pkg::*;
   ();
   logic    valid;
   logic    ready;
   logic    mode;
   sym_type symbol;
   logic    start_req;

   modport source (output valid, output mode, output symbol, output start_req, input ready);
   modport sink   (input valid, input mode, input symbol, input start_req, output ready);
endinterface

interface nss_rsp_if
   import nss_pkg::*;
   ();
   logic    valid;
   logic    ready;
   pos_type match_position;

   modport source (output valid, output match_position, input ready);
   modport sink   (input valid, input match_position, output ready);
endinterface

// ----- src/nss_ctrl.sv -----
// controller fsm: accepts one beat, runs the compare, manages the result register
module nss_ctrl
   import nss_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  nss_sts_type sts,
   output nss_cmd_type cmd
);

   logic state_ff;
   logic state_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic out_free;

   // handshake and commands
   assign req_ready     = (state_ff == ST_IDLE);
   assign out_free      = !rsp_valid_ff || rsp_ready;
   assign cmd.item_load = req_valid && req_ready;
   assign cmd.out_load  = (state_ff == ST_CMP) && sts.match && out_free;
   assign rsp_valid     = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.item_load) state_in = ST_CMP;
         end
         ST_CMP: begin
            if (!sts.match || out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result valid flag
   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- src/nss_datapath.sv -----
// datapath: pattern and text shift lines, counters, parallel compare, result register
module nss_datapath
   import nss_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  nss_cmd_type cmd,
   input  logic        mode,
   input  sym_type     symbol,
   input  logic        start_req,
   output nss_sts_type sts,
   output pos_type     match_position
);

   // pattern is kept newest-first so cell k lines up with window cell k
   sym_type            pat_ff [PAT_DEPTH];
   sym_type            win_ff [PAT_DEPTH];
   logic [LEN_W-1:0]   pat_len_ff;
   logic [LEN_W-1:0]   pat_len_in;
   logic               too_long_ff;
   logic               too_long_in;
   logic [CNT_W-1:0]   text_cnt_ff;
   logic [CNT_W-1:0]   text_cnt_in;
   logic               shifted_ff;
   logic               shifted_in;
   pos_type            pos_ff;

   logic [LEN_W-1:0]   len_base;
   logic [CNT_W-1:0]   cnt_base;
   logic               pat_shift;
   logic               win_shift;
   logic [PAT_DEPTH-1:0] hit;
   logic [CNT_W-1:0]   pos_diff;

   // item update
   always_comb begin
      len_base    = start_req ? '0 : pat_len_ff;
      cnt_base    = start_req ? '0 : text_cnt_ff;
      pat_len_in  = pat_len_ff;
      too_long_in = too_long_ff;
      text_cnt_in = text_cnt_ff;
      shifted_in  = shifted_ff;
      pat_shift   = 1'b0;
      win_shift   = 1'b0;
      if (cmd.item_load) begin
         shifted_in = 1'b0;
         if (mode == MODE_PATTERN) begin
            too_long_in = start_req ? 1'b0 : too_long_ff;
            pat_len_in  = len_base;
            if (LEN_W'(PAT_DEPTH) > len_base) begin
               pat_shift  = 1'b1;
               pat_len_in = len_base + LEN_W'(1);
            end else begin
               too_long_in = 1'b1;
            end
         end else begin
            text_cnt_in = cnt_base;
            if (CNT_W'(MAX_TEXT) > cnt_base) begin
               win_shift   = 1'b1;
               text_cnt_in = cnt_base + CNT_W'(1);
               shifted_in  = 1'b1;
            end
         end
      end
   end

   // pattern shift line
   always_ff @(posedge clock) begin
      if (pat_shift) begin
         pat_ff[0] <= symbol;
         for (int k = 1; k < PAT_DEPTH; k++) begin
            pat_ff[k] <= pat_ff[k-1];
         end
      end
   end

   // text window shift line
   always_ff @(posedge clock) begin
      if (win_shift) begin
         win_ff[0] <= symbol;
         for (int k = 1; k < PAT_DEPTH; k++) begin
            win_ff[k] <= win_ff[k-1];
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_len_ff  <= '0;
         too_long_ff <= 1'b0;
         text_cnt_ff <= '0;
         shifted_ff  <= 1'b0;
      end else begin
         pat_len_ff  <= pat_len_in;
         too_long_ff <= too_long_in;
         text_cnt_ff <= text_cnt_in;
         shifted_ff  <= shifted_in;
      end
   end

   // per-cell compare, cells past the pattern length always agree
   always_comb begin
      for (int k = 0; k < PAT_DEPTH; k++) begin
         hit[k] = (LEN_W'(k) >= pat_len_ff) || (win_ff[k] == pat_ff[k]);
      end
   end

   assign sts.match = shifted_ff && (pat_len_ff != '0) && !too_long_ff
                    && (CMP_W'(text_cnt_ff) >= CMP_W'(pat_len_ff)) && (&hit);

   // start position of the occurrence
   assign pos_diff = text_cnt_ff - CNT_W'(pat_len_ff);

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         pos_ff <= POS_W'(pos_diff);
      end
   end

   assign match_position = pos_ff;

endmodule

// ----- src/naive_substring_search.sv -----
// top level of the streaming exact substring search block
// Each request beat is a pattern or text character. An accepted beat is stored
// in the cycle it is taken; the next cycle compares the text window against all
// stored pattern characters in parallel, and req ready returns once the compare
// state is left. A match loads the result register and shows on rsp the cycle
// after the compare. A compare that found a match holds while an earlier result
// has not yet been taken. Patterns hold up to 32 characters; longer patterns and
// text past 65536 characters report nothing. No clearing pass.
module naive_substring_search
   import nss_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   nss_req_if.sink       req_bus,
   nss_rsp_if.source     rsp_bus
);

   nss_cmd_type cmd;
   nss_sts_type sts;

   // control
   nss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // storage and compare
   nss_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .mode           (req_bus.mode),
      .symbol         (req_bus.symbol),
      .start_req      (req_bus.start_req),
      .sts            (sts),
      .match_position (rsp_bus.match_position)
   );

endmodule

// ----- src/nss_checker.sv -----
// port-level checks for the substring search block, bound to the top level
module nss_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_mode,
   input logic rsp_valid,
   input logic rsp_ready
);

   // a pending result beat stays until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped before ready");

   // reset empties the result register
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // a fresh result comes from an accepted text beat, through the compare state and the result register
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) && !$past(reset) && !$past(reset, 2)
         |-> $past(req_valid && req_ready && req_mode, 2))
      else $error("result without a text beat");

   // the block takes one beat at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready held after an accepted beat");

endmodule

bind naive_substring_search nss_checker u_nss_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .req_mode  (req_bus.mode),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready)
);
